// ===== design/aap_pkg.sv =====
// Shared types and constants for the AIMD admission probability block.
`timescale 1ns / 1ps

package aap_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LatW     = 32;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned StepW    = 17;
  localparam int unsigned DecW     = StepW + SizeW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LATENCY_TARGET = 3'd0,
    REG_WINDOW         = 3'd1,
    REG_INCREASE_STEP  = 3'd2,
    REG_DECREASE_STEP  = 3'd3,
    REG_NORMALIZE      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LatW-1:0]  latency_target;
    logic [31:0]      window;
    logic [StepW-1:0] increase_step;
    logic [StepW-1:0] decrease_step;
    logic             normalize;
  } cfg_t;

  typedef struct packed {
    logic             miss;
    logic [DecW-1:0]  dec;
    logic [TimeW-1:0] now;
  } prep_t;

endpackage

// ===== design/aap_prep.sv =====
// Input register and product stage: miss test and decrement amount.
`timescale 1ns / 1ps

module aap_prep
  import aap_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [LatW-1:0]  latency_ns_i,
  input  logic [SizeW-1:0] size_mtus_i,
  input  logic [TimeW-1:0] now_us_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output prep_t            out_data_o
);

  logic             s1_v_q;
  logic [LatW-1:0]  lat_q;
  logic [SizeW-1:0] size_q;
  logic [TimeW-1:0] now_q;
  logic             s2_v_q;
  prep_t            s2_q;
  prep_t            s2_d;
  logic             s1_ready;
  logic             s2_ready;
  logic [TimeW-1:0] target_prod;
  logic [TimeW-1:0] limit;

  assign s2_ready   = ~s2_v_q | out_ready_i;
  assign s1_ready   = ~s1_v_q | s2_ready;
  assign in_ready_o = s1_ready;

  assign target_prod = TimeW'(cfg_i.latency_target) * TimeW'(size_q);
  assign limit       = cfg_i.normalize ? target_prod : {16'b0, cfg_i.latency_target};

  always_comb begin
    s2_d.miss = {16'b0, lat_q} > limit;
    s2_d.dec  = DecW'(cfg_i.decrease_step) * DecW'(size_q);
    s2_d.now  = now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      lat_q  <= latency_ns_i;
      size_q <= size_mtus_i;
      now_q  <= now_us_i;
    end
    if (s2_ready && s1_v_q) s2_q <= s2_d;
  end

  assign out_valid_o = s2_v_q;
  assign out_data_o  = s2_q;

endmodule

// ===== design/aap_update.sv =====
// Probability and window state update with the result register.
`timescale 1ns / 1ps

module aap_update
  import aap_pkg::*;
#(
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  prep_t                   in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PROB_FRAC_BITS:0] grant_prob_o,
  output logic                    missed_o,
  output logic                    adjusted_o
);

  localparam int unsigned PW = PROB_FRAC_BITS + 1;
  localparam int unsigned XW = DecW + 1;
  localparam logic [XW-1:0] OneX   = XW'(1) << PROB_FRAC_BITS;
  localparam logic [XW-1:0] FloorX = (OneX + XW'(5)) / XW'(10);
  localparam logic [PW-1:0] OneP   = OneX[PW-1:0];
  localparam logic [PW-1:0] FloorP = FloorX[PW-1:0];

  logic             out_v_q;
  logic             missed_q;
  logic             adj_q;
  logic [PW-1:0]    prob_q, prob_d;
  logic [TimeW-1:0] ws_q;
  logic             fire;
  logic [TimeW-1:0] elapsed;
  logic             win_hit;
  logic [XW-1:0]    prob_x;
  logic [XW-1:0]    dec_x;
  logic [XW-1:0]    diff_x;
  logic [XW-1:0]    sum_x;
  logic             adjust;

  assign in_ready_o = ~out_v_q | ~out_stall_i;
  assign fire       = in_valid_i & in_ready_o;

  assign elapsed = (in_data_i.now >= ws_q) ? (in_data_i.now - ws_q) : '0;
  assign win_hit = elapsed > {16'b0, cfg_i.window};

  assign prob_x = XW'(prob_q);
  assign dec_x  = XW'(in_data_i.dec);
  assign diff_x = prob_x - dec_x;
  assign sum_x  = prob_x + XW'(cfg_i.increase_step);
  assign adjust = in_data_i.miss | win_hit;

  always_comb begin
    prob_d = prob_q;
    if (in_data_i.miss) begin
      if ((dec_x >= prob_x) || (diff_x < FloorX)) prob_d = FloorP;
      else prob_d = diff_x[PW-1:0];
    end else if (win_hit) begin
      prob_d = (sum_x > OneX) ? OneP : sum_x[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      prob_q  <= OneP;
      ws_q    <= '0;
    end else begin
      if (in_ready_o) out_v_q <= in_valid_i;
      if (fire) begin
        prob_q <= prob_d;
        if (adjust) ws_q <= in_data_i.now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      missed_q <= in_data_i.miss;
      adj_q    <= adjust;
    end
  end

  assign out_valid_o  = out_v_q;
  assign grant_prob_o = prob_q;
  assign missed_o     = missed_q;
  assign adjusted_o   = adj_q;

endmodule

// ===== design/aimd_admission_probability.sv =====
// Top level of the AIMD admission probability block.
//
//   channel   dir  transfer condition            payload
//   in        in   in_valid_i  & !in_stall_o     latency_ns_i, size_mtus_i, now_us_i
//   out       out  out_valid_o & !out_stall_i    grant_prob_o, missed_o, adjusted_o
//   cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; an item passes the input register and
// the product/miss register before its result is presented from the result register.
// Stages: input register, product/miss register, state update into the result register.
// The state loop (probability, window start) closes within the last stage.
// Reset sets probability to one, window start to zero, config registers to their defaults.
// A stalled result holds; up to two more items queue behind it before in_stall_o rises.
`timescale 1ns / 1ps

module aimd_admission_probability
  import aap_pkg::*;
#(
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [LatW-1:0]         latency_ns_i,
  input  logic [SizeW-1:0]        size_mtus_i,
  input  logic [TimeW-1:0]        now_us_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PROB_FRAC_BITS:0] grant_prob_o,
  output logic                    missed_o,
  output logic                    adjusted_o
);

  localparam int unsigned PW = PROB_FRAC_BITS + 1;
  localparam logic [PW-1:0] OneP   = PW'(1) << PROB_FRAC_BITS;
  localparam logic [PW:0]   FloorW = ({1'b0, OneP} + (PW+1)'(5)) / (PW+1)'(10);
  localparam logic [PW-1:0] FloorP = FloorW[PW-1:0];

  cfg_t  cfg_q;
  logic  in_ready;
  logic  p_valid;
  logic  p_ready;
  prep_t p_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.latency_target <= 32'd100000;
      cfg_q.window         <= 32'd100;
      cfg_q.increase_step  <= 17'd655;
      cfg_q.decrease_step  <= 17'd655;
      cfg_q.normalize      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LATENCY_TARGET: cfg_q.latency_target <= cfg_data_i;
        REG_WINDOW:         cfg_q.window         <= cfg_data_i;
        REG_INCREASE_STEP:  cfg_q.increase_step  <= cfg_data_i[StepW-1:0];
        REG_DECREASE_STEP:  cfg_q.decrease_step  <= cfg_data_i[StepW-1:0];
        REG_NORMALIZE:      cfg_q.normalize      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  aap_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .latency_ns_i (latency_ns_i),
    .size_mtus_i  (size_mtus_i),
    .now_us_i     (now_us_i),
    .out_valid_o  (p_valid),
    .out_ready_i  (p_ready),
    .out_data_o   (p_data)
  );

  aap_update #(
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (p_valid),
    .in_ready_o   (p_ready),
    .in_data_i    (p_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .grant_prob_o (grant_prob_o),
    .missed_o     (missed_o),
    .adjusted_o   (adjusted_o)
  );

  assign in_stall_o = ~in_ready;

  a_miss_adjusts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && missed_o |-> adjusted_o)
    else $error("miss result without adjustment");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (grant_prob_o >= FloorP) && (grant_prob_o <= OneP))
    else $error("probability outside floor..one");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid && !p_ready |=> p_valid && $stable(p_data))
    else $error("internal stage lost or changed a held item");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> p_valid && out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== sim/aimd_admission_probability_tb.sv =====
// Self-checking testbench for the AIMD admission probability block.
`timescale 1ns / 1ps

import aap_pkg::*;

class aimd_scoreboard #(int unsigned FRAC = 16);

  typedef struct packed {
    logic [FRAC:0] prob;
    logic          missed;
    logic          adjusted;
  } verdict_t;

  localparam logic [63:0] ProbOne   = 64'd1 << FRAC;
  localparam logic [63:0] ProbFloor = (ProbOne + 64'd5) / 64'd10;

  logic [LatW-1:0]  target;
  logic [31:0]      window;
  logic [StepW-1:0] inc_step;
  logic [StepW-1:0] dec_step;
  logic             normalize;

  logic [63:0]      prob_level;
  logic [TimeW-1:0] window_start;

  verdict_t expected_verdicts[$];
  int failures;
  int results;
  int misses;
  int updates;
  int floor_hits;
  int cap_hits;

  function new();
    target       = 32'd100000;
    window       = 32'd100;
    inc_step     = 17'd655;
    dec_step     = 17'd655;
    normalize    = 1'b0;
    prob_level   = ProbOne;
    window_start = '0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_LATENCY_TARGET: target    = data[LatW-1:0];
      REG_WINDOW:         window    = data[31:0];
      REG_INCREASE_STEP:  inc_step  = data[StepW-1:0];
      REG_DECREASE_STEP:  dec_step  = data[StepW-1:0];
      REG_NORMALIZE:      normalize = data[0];
      default: ;
    endcase
  endfunction

  // Advance the probability and window state by one latency signal.
  function void note_transfer(logic [LatW-1:0] lat, logic [SizeW-1:0] size,
                              logic [TimeW-1:0] now);
    logic [63:0] limit;
    logic [63:0] dec;
    logic [63:0] elapsed;
    logic [63:0] sum;
    verdict_t    v;
    limit      = normalize ? 64'(target) * 64'(size) : 64'(target);
    v.missed   = 64'(lat) > limit;
    elapsed    = (now >= window_start) ? 64'(now - window_start) : 64'd0;
    v.adjusted = 1'b0;
    if (v.missed) begin
      dec = 64'(dec_step) * 64'(size);
      if (dec >= prob_level || prob_level - dec < ProbFloor) begin
        prob_level = ProbFloor;
        floor_hits++;
      end else begin
        prob_level = prob_level - dec;
      end
      v.adjusted = 1'b1;
    end else if (elapsed > 64'(window)) begin
      sum = prob_level + 64'(inc_step);
      if (sum > ProbOne) begin
        prob_level = ProbOne;
        cap_hits++;
      end else begin
        prob_level = sum;
      end
      v.adjusted = 1'b1;
    end
    if (v.adjusted) window_start = now;
    v.prob = prob_level[FRAC:0];
    expected_verdicts.insert(expected_verdicts.size(), v);
  endfunction

  function void check_result(logic [FRAC:0] prob, logic missed, logic adjusted);
    verdict_t v;
    if (expected_verdicts.size() == 0) begin
      $error("result transfer with no expectation pending: grant_prob %0d", prob);
      failures++;
      return;
    end
    v = expected_verdicts.pop_front();
    results++;
    if (v.missed) misses++;
    if (v.adjusted) updates++;
    if (prob !== v.prob) begin
      $error("grant_prob: expected %0d, actual %0d", v.prob, prob);
      failures++;
    end
    if (missed !== v.missed) begin
      $error("missed: expected %0d, actual %0d", v.missed, missed);
      failures++;
    end
    if (adjusted !== v.adjusted) begin
      $error("adjusted: expected %0d, actual %0d", v.adjusted, adjusted);
      failures++;
    end
  endfunction

  function int pending();
    return expected_verdicts.size();
  endfunction

endclass

module aimd_admission_probability_tb;

  localparam int unsigned ProbFracBits = 16;
  localparam time         RunLimit     = 2_000_000;
  // no register lives at this index; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i    = '0;
  logic [CfgDataW-1:0]   cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [LatW-1:0]       latency_ns_i = '0;
  logic [SizeW-1:0]      size_mtus_i  = '0;
  logic [TimeW-1:0]      now_us_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [ProbFracBits:0] grant_prob_o;
  logic                  missed_o;
  logic                  adjusted_o;

  aimd_scoreboard #(ProbFracBits) sb;

  int               send_idle_pct = 0;
  int               stall_pct     = 0;
  int               sent          = 0;
  logic [TimeW-1:0] now_clock     = '0;

  aimd_admission_probability #(
    .PROB_FRAC_BITS(ProbFracBits)
  ) u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .latency_ns_i,
    .size_mtus_i,
    .now_us_i,
    .out_valid_o,
    .out_stall_i,
    .grant_prob_o,
    .missed_o,
    .adjusted_o
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(grant_prob_o, missed_o, adjusted_o);
    end
  end

  task automatic send_signal(input logic [LatW-1:0] lat, input logic [SizeW-1:0] size,
                             input logic [TimeW-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    latency_ns_i <= lat;
    size_mtus_i  <= size;
    now_us_i     <= now;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(lat, size, now);
    sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] target, input logic [31:0] window,
                              input logic [31:0] inc, input logic [31:0] dec,
                              input logic [31:0] norm);
    drain_results();
    write_reg(REG_LATENCY_TARGET, target);
    write_reg(REG_WINDOW, window);
    write_reg(REG_INCREASE_STEP, inc);
    write_reg(REG_DECREASE_STEP, dec);
    write_reg(REG_NORMALIZE, norm);
  endtask

  task automatic directed_items();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_signal(32'd0, 16'd1, 48'd0);
    send_signal(32'd100000, 16'd1, 48'd50);
    send_signal(32'd100001, 16'd1, 48'd60);
    send_signal(32'hFFFF_FFFF, 16'hFFFF, 48'd61);
    send_signal(32'd0, 16'd1, 48'd161);
    send_signal(32'd0, 16'd1, 48'd162);
    // time going backwards counts as no elapsed time
    send_signal(32'd0, 16'd1, 48'd5);
    send_signal(32'd0, 16'h8000, 48'hFFFF_FFFF_FFFF);
    send_signal(32'd0, 16'd1, 48'd0);
    drain_results();
    // oversized increase step is masked to 17 bits and then capped
    write_reg(REG_INCREASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW, 32'd0);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_signal(32'hFFFF_FFFF, 16'd1, 48'd10);
    send_signal(32'd0, 16'd1, 48'd11);
    drain_results();
    write_reg(REG_NORMALIZE, 32'd1);
    write_reg(REG_LATENCY_TARGET, 32'd1000);
    write_reg(REG_DECREASE_STEP, 32'd0);
    // zero size makes the normalized target zero
    send_signal(32'd1, 16'd0, 48'd20);
    send_signal(32'd0, 16'd0, 48'd21);
    send_signal(32'd65535000, 16'hFFFF, 48'd22);
    send_signal(32'd65535001, 16'hFFFF, 48'd23);
    drain_results();
    write_reg(REG_DECREASE_STEP, 32'd65536);
    write_reg(REG_LATENCY_TARGET, 32'hFFFF_FFFF);
    send_signal(32'hFFFF_FFFF, 16'hFFFF, 48'd24);
    send_signal(32'd1, 16'd0, 48'd25);
    drain_results();
    write_reg(REG_NORMALIZE, 32'd0);
    send_signal(32'hFFFF_FFFF, 16'd1, 48'd26);
    drain_results();
    write_reg(REG_LATENCY_TARGET, 32'd0);
    send_signal(32'd1, 16'd1, 48'd27);
    send_signal(32'd0, 16'd1, 48'd27);
    now_clock = 48'd27;
  endtask

  task automatic random_phase(input int count, input int idle_pct, input int stall);
    logic [63:0]      limit;
    logic [63:0]      lat64;
    logic [LatW-1:0]  lat;
    logic [SizeW-1:0] size;
    logic [TimeW-1:0] step;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: size = 16'($urandom_range(1, 8));
        6, 7, 8:          size = 16'($urandom_range(1, 65535));
        default:          size = 16'hFFFF;
      endcase
      limit = sb.normalize ? 64'(sb.target) * 64'(size) : 64'(sb.target);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: lat64 = (limit < 64'd3) ? 64'($urandom_range(0, 6))
                                            : limit + 64'($urandom_range(0, 6)) - 64'd3;
        4, 5:       lat64 = 64'($urandom);
        6:          lat64 = 64'($urandom_range(0, 1000));
        7:          lat64 = 64'd0;
        8:          lat64 = 64'hFFFF_FFFF;
        default:    lat64 = limit / 2;
      endcase
      lat = (lat64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lat64[31:0];
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
          step = 48'($urandom_range(0, 3));
        10, 11, 12, 13, 14, 15, 16:
          step = (sb.window == 0) ? 48'($urandom_range(0, 2))
                                  : 48'(sb.window) + 48'($urandom_range(0, 2)) - 48'd1;
        17, 18:
          step = 48'($urandom_range(0, 1000));
        default:
          step = {16'($urandom), 32'($urandom)};
      endcase
      now_clock = now_clock + step;
      send_signal(lat, size, now_clock);
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic random_config();
    logic [31:0] target;
    logic [31:0] window;
    case ($urandom_range(0, 3))
      0:       target = 32'($urandom_range(0, 200000));
      1:       target = $urandom;
      2:       target = 32'($urandom_range(0, 2000));
      default: target = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endcase
    case ($urandom_range(0, 3))
      0:       window = 32'($urandom_range(0, 20));
      1:       window = 32'($urandom_range(0, 5000));
      2:       window = $urandom;
      default: window = 32'hFFFF_FFFF;
    endcase
    apply_config(target, window, 32'($urandom_range(0, 65536)),
                 32'($urandom_range(0, 65536)), 32'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();

    apply_config(32'd100000, 32'd100, 32'd655, 32'd655, 32'd0);
    random_phase(60, 0, 0);
    apply_config(32'd1000, 32'd20, 32'd3000, 32'd200, 32'd1);
    random_phase(60, 78, 0);
    apply_config(32'd50000, 32'd0, 32'd65536, 32'd65536, 32'd0);
    random_phase(60, 0, 78);
    apply_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1);
    random_phase(40, 13, 13);
    apply_config(32'hFFFF_FFFF, 32'd5, 32'd1000, 32'd65536, 32'd1);
    random_phase(40, 13, 13);
    for (int k = 0; k < 4; k++) begin
      random_config();
      case (k)
        0:       random_phase(45, 0, 0);
        1:       random_phase(45, 78, 0);
        2:       random_phase(45, 0, 78);
        default: random_phase(45, 13, 13);
      endcase
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("sent %0d latency signals, checked %0d results across %0d settings",
             sent, sb.results, 10);
    $display("misses %0d, probability updates %0d, floor reached %0d, cap reached %0d",
             sb.misses, sb.updates, sb.floor_hits, sb.cap_hits);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("aimd_admission_probability regression: pass");
    end else begin
      $display("aimd_admission_probability regression: fail");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("timeout with %0d results still pending", sb.pending());
    $display("aimd_admission_probability regression: fail");
    $finish;
  end

endmodule

// ===== aimd_admission_probability.f =====
design/aap_pkg.sv
design/aap_prep.sv
design/aap_update.sv
design/aimd_admission_probability.sv
sim/aimd_admission_probability_tb.sv
